// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int CDQ_DEPTH = 8;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
  } cmd_t;

  // Datapath to the rest of the block.
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

// ===== hdl/cdq_op_if.sv =====
// ----------------------------------------------------------------------------
// cdq_op_if
// Operation request channel: valid/ready with operation code and push value.
// ----------------------------------------------------------------------------
interface cdq_op_if
  import cdq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

// ===== hdl/cdq_res_if.sv =====
// ----------------------------------------------------------------------------
// cdq_res_if
// Result channel: valid/ready with read data and status.
// ----------------------------------------------------------------------------
interface cdq_res_if
  import cdq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  data;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, data, status, input ready);
  modport sink   (input valid, data, status, output ready);
endinterface

// ===== hdl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Handshake controller: takes one beat, then holds the result until taken.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.take   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cdq_dpath.sv =====
// ----------------------------------------------------------------------------
// cdq_dpath
// Ring pointers, entry memory and result registers of the deque.
// ----------------------------------------------------------------------------
module cdq_dpath
  import cdq_pkg::*;
#(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  input  logic [OP_W-1:0]            operation,
  input  logic signed [VALUE_W-1:0]  value,
  output logic signed [VALUE_W-1:0]  data,
  output logic [STATUS_W-1:0]        status,
  output stat_t                      stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_q;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] tail_dec;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] raddr;
  logic             we;
  logic             rd_ok;
  logic             rd_ok_next;
  status_t          status_q;
  status_t          status_next;

  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST : head - 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST : tail - 1'b1;

  assign stat.empty = (head == tail);
  assign stat.full  = (head == tail_inc);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    we          = 1'b0;
    waddr       = head;
    raddr       = tail;
    rd_ok_next  = 1'b0;
    status_next = STAT_OK;
    case (op_t'(operation))
      OP_PUSH_FRONT: begin
        if (stat.full) begin
          status_next = STAT_FULL;
        end else begin
          we        = 1'b1;
          waddr     = head;
          head_next = head_dec;
        end
      end
      OP_PUSH_REAR: begin
        if (stat.full) begin
          status_next = STAT_FULL;
        end else begin
          we        = 1'b1;
          waddr     = tail_inc;
          tail_next = tail_inc;
        end
      end
      OP_POP_FRONT: begin
        if (stat.empty) begin
          status_next = STAT_EMPTY;
        end else begin
          raddr      = head_inc;
          rd_ok_next = 1'b1;
          head_next  = head_inc;
        end
      end
      OP_POP_REAR: begin
        if (stat.empty) begin
          status_next = STAT_EMPTY;
        end else begin
          raddr      = tail;
          rd_ok_next = 1'b1;
          tail_next  = tail_dec;
        end
      end
      OP_PEEK_FRONT: begin
        if (stat.empty) begin
          status_next = STAT_EMPTY;
        end else begin
          raddr      = head_inc;
          rd_ok_next = 1'b1;
        end
      end
      OP_PEEK_REAR: begin
        if (stat.empty) begin
          status_next = STAT_EMPTY;
        end else begin
          raddr      = tail;
          rd_ok_next = 1'b1;
        end
      end
      default: begin
        // Unused codes leave the deque alone and report ok with zero data.
        status_next = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      rd_ok    <= 1'b0;
      status_q <= STAT_OK;
    end else if (cmd.take) begin
      head     <= head_next;
      tail     <= tail_next;
      rd_ok    <= rd_ok_next;
      status_q <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && we) begin
      mem[waddr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_q <= mem[raddr];
    end
  end

  assign data   = rd_ok ? $signed(rd_q) : '0;
  assign status = status_q;

endmodule

// ===== hdl/circular_deque_unit.sv =====
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue in a ring of DEPTH entries holding up to DEPTH-1 values.
// ----------------------------------------------------------------------------
// Latency: the result beat is valid in the cycle after the request beat.
// Only one operation is in flight: the controller takes a request, then
// presents its result until taken, since the entry memory has a registered
// read port. Reset clears both ring pointers (deque empty) and the handshake
// state; the entry memory itself is not cleared.
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  cdq_op_if.sink     req,
  cdq_res_if.source  rsp
);

  cmd_t  cmd;
  stat_t stat;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (req.operation),
    .value     (req.value),
    .data      (rsp.data),
    .status    (rsp.status),
    .stat      (stat)
  );

  // The ring can never look empty and full at once.
  a_not_empty_and_full: assert property (@(posedge clk) disable iff (rst)
    !(stat.empty && stat.full))
    else $error("deque reports empty and full together");

  // A refused operation always returns zero data.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == STAT_FULL || rsp.status == STAT_EMPTY)
      |-> rsp.data == '0)
    else $error("refused operation returned nonzero data");

  // A taken request shows its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> rsp.valid)
    else $error("result did not follow accepted request");

  // A pending result blocks new requests.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request accepted while a result is pending");

endmodule

// ===== tb/sv/circular_deque_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit_tb
// Self-checking bench for the circular deque unit. It sends pushes, pops,
// peeks and the spare operation codes. It mirrors the ring and both slot
// pointers to predict every result beat, and it compares each returned beat
// with the oldest prediction. Both ends idle at random, with two long result
// stalls and a few full drains.
// ----------------------------------------------------------------------------
module circular_deque_unit_tb;
  import cdq_pkg::*;

  // Operation codes outside op_t: the block must answer them with ok and zero.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_COUNT  = 19;
  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE_TIME  = 8;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [VALUE_W-1:0]  data;
    logic [STATUS_W-1:0] status;
  } deque_result_t;

  // Mirrors the ring contents and pointers and holds the results still owed.
  class deque_tracker;
    logic [VALUE_W-1:0] ring [CDQ_DEPTH];
    int unsigned        head_slot;
    int unsigned        tail_slot;
    deque_result_t      owed_results [$];
    int unsigned        errors;

    function new();
      head_slot = 0;
      tail_slot = 0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_REPORTS)
        $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
      deque_result_t res;
      bit            is_empty;
      bit            is_full;
      is_empty   = (head_slot == tail_slot);
      is_full    = (head_slot == (tail_slot + 1) % CDQ_DEPTH);
      res.data   = '0;
      res.status = STAT_OK;
      case (op)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            res.status = STAT_FULL;
          end else begin
            ring[head_slot] = value;
            head_slot = (head_slot + CDQ_DEPTH - 1) % CDQ_DEPTH;
          end
        end
        OP_PUSH_REAR: begin
          if (is_full) begin
            res.status = STAT_FULL;
          end else begin
            tail_slot = (tail_slot + 1) % CDQ_DEPTH;
            ring[tail_slot] = value;
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            res.status = STAT_EMPTY;
          end else begin
            head_slot = (head_slot + 1) % CDQ_DEPTH;
            res.data = ring[head_slot];
          end
        end
        OP_POP_REAR: begin
          if (is_empty) begin
            res.status = STAT_EMPTY;
          end else begin
            res.data = ring[tail_slot];
            tail_slot = (tail_slot + CDQ_DEPTH - 1) % CDQ_DEPTH;
          end
        end
        OP_PEEK_FRONT: begin
          if (is_empty) res.status = STAT_EMPTY;
          else res.data = ring[(head_slot + 1) % CDQ_DEPTH];
        end
        OP_PEEK_REAR: begin
          if (is_empty) res.status = STAT_EMPTY;
          else res.data = ring[tail_slot];
        end
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    task check_result(logic [VALUE_W-1:0] data, logic [STATUS_W-1:0] status);
      deque_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%h status=%0d", data, status));
      end else begin
        want = owed_results.pop_front();
        if (data !== want.data)
          report_mismatch($sformatf("data got %h want %h", data, want.data));
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdq_op_if  req_if ();
  cdq_res_if rsp_if ();

  circular_deque_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  deque_tracker tracker = new();

  int unsigned cycles      = 0;
  int unsigned snd_max_gap = 3;
  int unsigned rcv_max_gap = 3;
  bit          long_hold   = 1'b0;

  always #4 clk = ~clk;

  initial begin
    req_if.valid     = 1'b0;
    req_if.operation = '0;
    req_if.value     = '0;
    rsp_if.ready     = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The result is checked before the new request is noted, since a beat
  // leaving in the same cycle always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready)
        tracker.check_result(rsp_if.data, rsp_if.status);
      if (req_if.valid && req_if.ready)
        tracker.note_request(req_if.operation, req_if.value);
    end
  end

  // Result side: a random wait before each beat, or one long stall on request.
  initial begin : result_sink
    int unsigned gap;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      gap = long_hold ? HOLD_CYCLES : $urandom_range(0, rcv_max_gap);
      long_hold = 1'b0;
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // Entered just after a rising edge; returns at the edge that takes the beat.
  task automatic send_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = $urandom_range(0, snd_max_gap);
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= value;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] draw_op(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2)
      return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    if (roll < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    case ($urandom_range(0, 3))
      0:       return OP_POP_FRONT;
      1:       return OP_POP_REAR;
      2:       return OP_PEEK_FRONT;
      default: return OP_PEEK_REAR;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned push_pct;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Everything that reads must be refused on an empty deque.
    send_op(OP_POP_FRONT,  32'h1234_5678);
    send_op(OP_POP_REAR,   32'h0);
    send_op(OP_PEEK_FRONT, 32'h0);
    send_op(OP_PEEK_REAR,  32'hFFFF_FFFF);
    send_op(OP_SPARE_LO,   32'hDEAD_BEEF);
    // Fill from both ends with extreme words until full, then overfill.
    send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_op(OP_PUSH_REAR,  32'h8000_0000);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(OP_PUSH_REAR,  32'h0000_0000);
    send_op(OP_PUSH_FRONT, 32'h5555_5555);
    send_op(OP_PUSH_REAR,  32'hAAAA_AAAA);
    send_op(OP_PUSH_FRONT, 32'h0000_0001);
    send_op(OP_PUSH_FRONT, 32'h1111_1111);
    send_op(OP_PUSH_REAR,  32'h2222_2222);
    send_op(OP_SPARE_HI,   32'h3333_3333);
    send_op(OP_PEEK_FRONT, 32'h0);
    send_op(OP_PEEK_REAR,  32'h0);
    send_op(OP_POP_FRONT,  32'h0);
    send_op(OP_POP_REAR,   32'h0);
    send_op(OP_PEEK_FRONT, 32'h0);
    wait_drained();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      // Some phases run with no idling on one or both ends.
      snd_max_gap = (phase % 4 == 1) ? 0 : 3;
      rcv_max_gap = (phase % 5 == 2) ? 0 : 3;
      if (phase == 3 || phase == 11) begin
        snd_max_gap = 0;
        long_hold   = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_op(draw_op(push_pct), draw_value());
      if (phase % 6 == 5)
        wait_drained();
    end

    wait_drained();
    repeat (SETTLE_TIME) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
